@@ design/tdg_pkg.sv @@
// ----------------------------------------------------------------------------
// tdg_pkg
// Shared types and constants of the transit dip grouper.
// ----------------------------------------------------------------------------
package tdg_pkg;

  localparam int unsigned FluxW = 16;
  localparam int unsigned DateW = 32;
  localparam int unsigned CfgW  = 32;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [FluxW-1:0] PassThresholdReset = 16'd16384;
  localparam logic [DateW-1:0] MaxDurationReset   = 32'd65536;

  // Deepest flux kept while no group is open (2.0 in Q2.14).
  localparam logic [FluxW-1:0] NoGroupFlux = 16'd32768;

  localparam logic CfgPassThreshold = 1'b0;
  localparam logic CfgMaxDuration   = 1'b1;

  typedef struct packed {
    logic [FluxW-1:0] flux;
    logic [DateW-1:0] date;
    logic             last;
    logic             pass;
  } item_t;

  typedef struct packed {
    logic [FluxW-1:0] flux;
    logic [DateW-1:0] date;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic we;
    logic idx;
    logic [CfgW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ design/tdg_front.sv @@
// ----------------------------------------------------------------------------
// tdg_front
// Accepts samples and tags each one with its threshold pass decision.
// ----------------------------------------------------------------------------
module tdg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tdg_pkg::cfg_wr_t               cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tdg_pkg::FluxW-1:0]      flux_i,
  input  logic [tdg_pkg::DateW-1:0]      date_i,
  input  logic                           last_i,
  output tdg_pkg::hs_t                   push_o,
  input  logic                           push_ready_i,
  output tdg_pkg::item_t                 item_o
);

  logic [tdg_pkg::FluxW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tdg_pkg::PassThresholdReset;
    end else if (cfg_i.we && cfg_i.idx == tdg_pkg::CfgPassThreshold) begin
      thr_q <= cfg_i.wdata[tdg_pkg::FluxW-1:0];
    end
  end

  assign in_ready_o   = push_ready_i;
  assign push_o.valid = in_valid_i;
  assign push_o.ready = push_ready_i;

  always_comb begin
    item_o.flux = flux_i;
    item_o.date = date_i;
    item_o.last = last_i;
    item_o.pass = (flux_i <= thr_q);
  end

endmodule

@@ design/tdg_queue.sv @@
// ----------------------------------------------------------------------------
// tdg_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module tdg_queue #(
  parameter int unsigned Depth = tdg_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tdg_pkg::hs_t   push_i,
  output logic           push_ready_o,
  input  tdg_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output tdg_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tdg_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i.valid && push_i.ready;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/tdg_back.sv @@
// ----------------------------------------------------------------------------
// tdg_back
// Keeps the open transit, closes and flushes groups, and buffers results.
// ----------------------------------------------------------------------------
module tdg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdg_pkg::cfg_wr_t          cfg_i,
  input  logic                      head_valid_i,
  input  tdg_pkg::item_t            head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tdg_pkg::result_t          out_o
);

  logic [tdg_pkg::DateW-1:0] dur_q;
  logic [tdg_pkg::DateW-1:0] gs_q, gs_d;
  logic [tdg_pkg::FluxW-1:0] df_q, df_d;
  logic [tdg_pkg::DateW-1:0] dd_q, dd_d;

  logic             out_valid_q, pend_valid_q;
  tdg_pkg::result_t out_q, pend_q;

  logic [tdg_pkg::DateW:0] span;
  logic exceeds, close_emit, flush_emit, out_free;
  tdg_pkg::result_t close_res, flush_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= tdg_pkg::MaxDurationReset;
    end else if (cfg_i.we && cfg_i.idx == tdg_pkg::CfgMaxDuration) begin
      dur_q <= cfg_i.wdata[tdg_pkg::DateW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_valid_i && out_free && !pend_valid_q;

  always_comb begin
    span    = {1'b0, head_i.date} - {1'b0, gs_q};
    exceeds = !span[tdg_pkg::DateW] && (span[tdg_pkg::DateW-1:0] > dur_q);
    gs_d = gs_q;
    df_d = df_q;
    dd_d = dd_q;
    close_emit = 1'b0;
    close_res.flux = df_q;
    close_res.date = dd_q;
    close_res.last_of_run = 1'b0;
    if (head_i.pass) begin
      if (exceeds) begin
        close_emit = !(df_q == tdg_pkg::NoGroupFlux && dd_q == '0);
        df_d = head_i.flux;
        dd_d = head_i.date;
        gs_d = head_i.date;
      end else if (head_i.flux < df_q) begin
        df_d = head_i.flux;
        dd_d = head_i.date;
      end
    end
    flush_emit = 1'b0;
    flush_res.flux = df_d;
    flush_res.date = dd_d;
    flush_res.last_of_run = 1'b1;
    if (head_i.last) begin
      flush_emit = !(df_d == tdg_pkg::NoGroupFlux && dd_d == '0);
      gs_d = '0;
      df_d = tdg_pkg::NoGroupFlux;
      dd_d = '0;
    end
    close_res.last_of_run = !flush_emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q         <= '0;
      df_q         <= tdg_pkg::NoGroupFlux;
      dd_q         <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        gs_q <= gs_d;
        df_q <= df_d;
        dd_q <= dd_d;
      end
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else if (pop_o && (close_emit || flush_emit)) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= close_emit && flush_emit;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (pop_o) begin
        out_q  <= close_emit ? close_res : flush_res;
        pend_q <= flush_res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ design/transit_dip_grouper_core.sv @@
// ----------------------------------------------------------------------------
// transit_dip_grouper_core
// Groups passing light-curve samples into transits and emits their peaks.
// Each result is registered before it is offered. Throughput: one sample
// per cycle unless the output stalls; a sample that closes one transit and
// flushes another holds the back part until its second result is loaded.
// Reset: asynchronous, active low; control state and the open group reset.
// ----------------------------------------------------------------------------
module transit_dip_grouper_core #(
  parameter int unsigned QueueDepth = tdg_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [tdg_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tdg_pkg::FluxW-1:0] flux_i,
  input  logic [tdg_pkg::DateW-1:0] date_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tdg_pkg::FluxW-1:0] peak_flux_o,
  output logic [tdg_pkg::DateW-1:0] peak_date_o,
  output logic                      last_of_run_o
);

  tdg_pkg::cfg_wr_t cfg;
  tdg_pkg::hs_t     push;
  tdg_pkg::item_t   push_item, head;
  tdg_pkg::result_t res;
  logic push_ready, head_valid, pop;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  tdg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .flux_i       (flux_i),
    .date_i       (date_i),
    .last_i       (last_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  tdg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_item_o   (head)
  );

  tdg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign peak_flux_o   = res.flux;
  assign peak_date_o   = res.date;
  assign last_of_run_o = res.last_of_run;

endmodule
